### sv/suwm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package suwm_pkg;

    localparam int STACK_SIZE_BITS   = 20;
    localparam int THREAD_COUNT_BITS = 8;
    localparam int UNUSED_BITS       = 20;
    localparam int PCT_BITS          = 7;
    localparam int PCT_SCALE         = 100;
    localparam int ERR_BITS          = 4;
    localparam int TIME_BITS         = 32;
    localparam int COUNT_BITS        = 32;
    localparam int APB_ADDR_BITS     = 3;
    localparam int APB_DATA_BITS     = 32;

    // dividend of the percent division: used * 100
    localparam int PROD_BITS    = STACK_SIZE_BITS + PCT_BITS;
    localparam int DIV_CNT_BITS = $clog2(PROD_BITS + 1);
    localparam int WIDE_BITS    = (STACK_SIZE_BITS > UNUSED_BITS) ? STACK_SIZE_BITS
                                                                  : UNUSED_BITS;

    typedef logic [STACK_SIZE_BITS-1:0]   stk_size_t;
    typedef logic [UNUSED_BITS-1:0]       unused_t;
    typedef logic [PCT_BITS-1:0]          pct_t;
    typedef logic [ERR_BITS-1:0]          err_t;
    typedef logic [TIME_BITS-1:0]         time_ms_t;
    typedef logic [COUNT_BITS-1:0]        count_t;
    typedef logic [THREAD_COUNT_BITS-1:0] thr_count_t;
    typedef logic [APB_ADDR_BITS-1:0]     apb_addr_t;
    typedef logic [APB_DATA_BITS-1:0]     apb_data_t;

    localparam thr_count_t THREAD_COUNT_MAX  = '1;
    localparam unused_t    WARN_UNUSED_RESET = UNUSED_BITS'(256);
    localparam pct_t       WARN_PCT_RESET    = PCT_BITS'(90);

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_WARN_UNUSED = 1'b0,
        REG_WARN_PCT    = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_COMMIT
    } ctl_state_t;

    typedef struct packed {
        unused_t warn_unused;
        pct_t    warn_pct;
    } cfg_t;

    typedef struct packed {
        logic      start;
        stk_size_t size;
        stk_size_t used;
    } div_req_t;

    typedef struct packed {
        logic done;
        pct_t pct;
    } div_rsp_t;

    typedef struct packed {
        logic      fire;
        stk_size_t size;
        unused_t   unused;
        err_t      err;
        logic      last;
        time_ms_t  now;
        pct_t      pct;
    } commit_t;

    // candidate worse than the other record
    function automatic logic beats(stk_size_t c_size, unused_t c_unused, pct_t c_pct,
                                   stk_size_t o_size, unused_t o_unused, pct_t o_pct);
        logic r;
        if (c_size == '0)
        begin
            r = 1'b0;
        end
        else if (o_size == '0)
        begin
            r = 1'b1;
        end
        else if (c_pct != o_pct)
        begin
            r = (c_pct > o_pct);
        end
        else
        begin
            r = (c_unused < o_unused);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### sv/suwm_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module suwm_cfg_regs (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire suwm_pkg::apb_addr_t  paddr,
    input  wire suwm_pkg::apb_data_t  pwdata,
    output suwm_pkg::apb_data_t       prdata,
    output logic                      pready,
    output suwm_pkg::cfg_t            cfg
);
    import suwm_pkg::*;

    unused_t  warn_unused_reg;
    pct_t     warn_pct_reg;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warn_unused_reg <= WARN_UNUSED_RESET;
            warn_pct_reg    <= WARN_PCT_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_WARN_UNUSED: warn_unused_reg <= pwdata[UNUSED_BITS-1:0];
                REG_WARN_PCT:    warn_pct_reg    <= pwdata[PCT_BITS-1:0];
                default:         warn_pct_reg    <= warn_pct_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_WARN_UNUSED: prdata = APB_DATA_BITS'(warn_unused_reg);
            REG_WARN_PCT:    prdata = APB_DATA_BITS'(warn_pct_reg);
            default:         prdata = '0;
        endcase
    end

    assign cfg.warn_unused = warn_unused_reg;
    assign cfg.warn_pct    = warn_pct_reg;

endmodule

`default_nettype wire

### sv/suwm_pct_div.sv
`timescale 1ns / 1ps
`default_nettype none

// bit-serial restoring division of used*100 by size, one dividend bit a cycle
module suwm_pct_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire suwm_pkg::div_req_t req,
    output suwm_pkg::div_rsp_t      rsp
);
    import suwm_pkg::*;

    logic                    busy_reg,  busy_next;
    logic                    done_reg,  done_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg,   cnt_next;
    logic [PROD_BITS-1:0]    dvd_reg,   dvd_next;
    stk_size_t               rem_reg,   rem_next;
    stk_size_t               size_reg,  size_next;
    pct_t                    quo_reg,   quo_next;

    logic [STACK_SIZE_BITS:0] trial;
    logic [STACK_SIZE_BITS:0] diff;
    logic                     ge;

    assign trial = {rem_reg, dvd_reg[PROD_BITS-1]};
    assign ge    = (trial >= {1'b0, size_reg});
    assign diff  = trial - {1'b0, size_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        size_next = size_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_BITS'(PROD_BITS);
            dvd_next  = PROD_BITS'(req.used) * PROD_BITS'(PCT_SCALE);
            rem_next  = '0;
            size_next = req.size;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[STACK_SIZE_BITS-1:0] : trial[STACK_SIZE_BITS-1:0];
            quo_next = {quo_reg[PCT_BITS-2:0], ge};
            dvd_next = {dvd_reg[PROD_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - DIV_CNT_BITS'(1);
            if (cnt_reg == DIV_CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        size_reg <= size_next;
        quo_reg  <= quo_next;
    end

    assign rsp.done = done_reg;
    assign rsp.pct  = quo_reg;

endmodule

`default_nettype wire

### sv/suwm_scan_acc.sv
`timescale 1ns / 1ps
`default_nettype none

// per-scan and all-time statistics, worst tracking and the result register
module suwm_scan_acc (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire suwm_pkg::commit_t   cmt,
    input  wire suwm_pkg::cfg_t      cfg,
    input  wire logic                result_ready,
    output logic                     slot_free,
    output logic                     result_valid,
    output suwm_pkg::count_t         scans_completed,
    output suwm_pkg::count_t         warn_total,
    output logic                     scan_warning,
    output suwm_pkg::thr_count_t     threads_seen,
    output suwm_pkg::err_t           scan_error,
    output suwm_pkg::stk_size_t      worst_now_size,
    output suwm_pkg::unused_t        worst_now_unused,
    output suwm_pkg::pct_t           worst_now_percent,
    output suwm_pkg::stk_size_t      worst_ever_size,
    output suwm_pkg::unused_t        worst_ever_unused,
    output suwm_pkg::pct_t           worst_ever_percent,
    output suwm_pkg::time_ms_t       scan_end_time_ms
);
    import suwm_pkg::*;

    stk_size_t  cur_size_reg;
    unused_t    cur_unused_reg;
    pct_t       cur_pct_reg;
    stk_size_t  ever_size_reg;
    unused_t    ever_unused_reg;
    pct_t       ever_pct_reg;
    thr_count_t thr_cnt_reg;
    count_t     scan_warn_cnt_reg;
    logic       scan_warn_flag_reg;
    err_t       scan_err_reg;
    count_t     total_warn_reg;
    count_t     total_scan_reg;

    logic       out_valid_reg;
    count_t     o_scan_count_reg;
    count_t     o_warn_total_reg;
    logic       o_warning_reg;
    thr_count_t o_threads_reg;
    err_t       o_err_reg;
    stk_size_t  o_now_size_reg;
    unused_t    o_now_unused_reg;
    pct_t       o_now_pct_reg;
    stk_size_t  o_ever_size_reg;
    unused_t    o_ever_unused_reg;
    pct_t       o_ever_pct_reg;
    time_ms_t   o_time_reg;

    // values after folding in the committed report
    logic       measured;
    logic       cand_wins;
    logic       warn;
    logic       keep_ever;
    stk_size_t  cur_size_upd;
    unused_t    cur_unused_upd;
    pct_t       cur_pct_upd;
    thr_count_t thr_cnt_upd;
    count_t     warn_cnt_upd;
    logic       warn_flag_upd;
    err_t       err_upd;
    count_t     total_warn_upd;
    stk_size_t  ever_size_upd;
    unused_t    ever_unused_upd;
    pct_t       ever_pct_upd;
    logic       close_scan;

    always_comb
    begin
        measured  = (cmt.err == '0);
        cand_wins = measured && beats(cmt.size, cmt.unused, cmt.pct,
                                      cur_size_reg, cur_unused_reg, cur_pct_reg);
        warn      = measured && (cmt.size != '0) &&
                    ((cmt.unused < cfg.warn_unused) || (cmt.pct >= cfg.warn_pct));

        cur_size_upd   = cand_wins ? cmt.size   : cur_size_reg;
        cur_unused_upd = cand_wins ? cmt.unused : cur_unused_reg;
        cur_pct_upd    = cand_wins ? cmt.pct    : cur_pct_reg;

        thr_cnt_upd   = (thr_cnt_reg != THREAD_COUNT_MAX) ? thr_cnt_reg + thr_count_t'(1)
                                                          : thr_cnt_reg;
        warn_cnt_upd  = warn ? scan_warn_cnt_reg + count_t'(1) : scan_warn_cnt_reg;
        warn_flag_upd = scan_warn_flag_reg | warn;
        err_upd       = measured ? scan_err_reg : cmt.err;

        total_warn_upd = total_warn_reg + warn_cnt_upd;
        keep_ever      = beats(ever_size_reg, ever_unused_reg, ever_pct_reg,
                               cur_size_upd, cur_unused_upd, cur_pct_upd);
        ever_size_upd   = keep_ever ? ever_size_reg   : cur_size_upd;
        ever_unused_upd = keep_ever ? ever_unused_reg : cur_unused_upd;
        ever_pct_upd    = keep_ever ? ever_pct_reg    : cur_pct_upd;

        close_scan = cmt.fire && cmt.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_size_reg       <= '0;
            cur_unused_reg     <= '0;
            cur_pct_reg        <= '0;
            ever_size_reg      <= '0;
            ever_unused_reg    <= '0;
            ever_pct_reg       <= '0;
            thr_cnt_reg        <= '0;
            scan_warn_cnt_reg  <= '0;
            scan_warn_flag_reg <= 1'b0;
            scan_err_reg       <= '0;
            total_warn_reg     <= '0;
            total_scan_reg     <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cmt.fire)
            begin
                if (cmt.last)
                begin
                    cur_size_reg       <= '0;
                    cur_unused_reg     <= '0;
                    cur_pct_reg        <= '0;
                    thr_cnt_reg        <= '0;
                    scan_warn_cnt_reg  <= '0;
                    scan_warn_flag_reg <= 1'b0;
                    scan_err_reg       <= '0;
                    ever_size_reg      <= ever_size_upd;
                    ever_unused_reg    <= ever_unused_upd;
                    ever_pct_reg       <= ever_pct_upd;
                    total_warn_reg     <= total_warn_upd;
                    total_scan_reg     <= total_scan_reg + count_t'(1);
                end
                else
                begin
                    cur_size_reg       <= cur_size_upd;
                    cur_unused_reg     <= cur_unused_upd;
                    cur_pct_reg        <= cur_pct_upd;
                    thr_cnt_reg        <= thr_cnt_upd;
                    scan_warn_cnt_reg  <= warn_cnt_upd;
                    scan_warn_flag_reg <= warn_flag_upd;
                    scan_err_reg       <= err_upd;
                end
            end
            priority if (close_scan)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= out_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (close_scan)
        begin
            o_scan_count_reg  <= total_scan_reg + count_t'(1);
            o_warn_total_reg  <= total_warn_upd;
            o_warning_reg     <= warn_flag_upd;
            o_threads_reg     <= thr_cnt_upd;
            o_err_reg         <= err_upd;
            o_now_size_reg    <= cur_size_upd;
            o_now_unused_reg  <= cur_unused_upd;
            o_now_pct_reg     <= cur_pct_upd;
            o_ever_size_reg   <= ever_size_upd;
            o_ever_unused_reg <= ever_unused_upd;
            o_ever_pct_reg    <= ever_pct_upd;
            o_time_reg        <= cmt.now;
        end
    end

    assign slot_free          = !out_valid_reg || result_ready;
    assign result_valid       = out_valid_reg;
    assign scans_completed    = o_scan_count_reg;
    assign warn_total         = o_warn_total_reg;
    assign scan_warning       = o_warning_reg;
    assign threads_seen       = o_threads_reg;
    assign scan_error         = o_err_reg;
    assign worst_now_size     = o_now_size_reg;
    assign worst_now_unused   = o_now_unused_reg;
    assign worst_now_percent  = o_now_pct_reg;
    assign worst_ever_size    = o_ever_size_reg;
    assign worst_ever_unused  = o_ever_unused_reg;
    assign worst_ever_percent = o_ever_pct_reg;
    assign scan_end_time_ms   = o_time_reg;

endmodule

`default_nettype wire

### sv/stack_usage_watermark_monitor_core.sv
// Stack usage watermark monitor: takes one per-thread stack report per item
// transfer and returns one status transfer when a report marked last of
// scan closes the scan. After a report with a nonzero error code or a zero
// stack size, the next report can transfer once the block has passed through
// its commit step and back to idle; after a measured report it also waits for
// the bit-serial percent divider, which walks the 27-bit product
// used*100 one bit per cycle against the 20-bit stack size, and then for
// the quotient to be taken, the report committed and the block back in idle.
// One report is in work at a time, and item_ready is high only while the
// block is idle. The status sits in an output register, so the next report
// is taken while a status still waits; a closing report waits in its commit
// step only while the previous status has not been taken. Thresholds come
// from the register port (warn_unused_bytes at 0x0, warn_usage_percent at
// 0x4) and are meant to be written while idle.
`timescale 1ns / 1ps
`default_nettype none

module stack_usage_watermark_monitor_core (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // register port
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire suwm_pkg::apb_addr_t  paddr,
    input  wire suwm_pkg::apb_data_t  pwdata,
    output suwm_pkg::apb_data_t       prdata,
    output logic                      pready,
    // report channel
    input  wire logic                 item_valid,
    output logic                      item_ready,
    input  wire suwm_pkg::stk_size_t  stack_bytes,
    input  wire suwm_pkg::unused_t    unused_bytes,
    input  wire suwm_pkg::err_t       report_error,
    input  wire logic                 last_of_scan,
    input  wire suwm_pkg::time_ms_t   scan_time_ms,
    // status channel
    output logic                      result_valid,
    input  wire logic                 result_ready,
    output suwm_pkg::count_t          scans_completed,
    output suwm_pkg::count_t          warn_total,
    output logic                      scan_warning,
    output suwm_pkg::thr_count_t      threads_seen,
    output suwm_pkg::err_t            scan_error,
    output suwm_pkg::stk_size_t       worst_now_size,
    output suwm_pkg::unused_t         worst_now_unused,
    output suwm_pkg::pct_t            worst_now_percent,
    output suwm_pkg::stk_size_t       worst_ever_size,
    output suwm_pkg::unused_t         worst_ever_unused,
    output suwm_pkg::pct_t            worst_ever_percent,
    output suwm_pkg::time_ms_t        scan_end_time_ms
);
    import suwm_pkg::*;

    cfg_t       cfg;
    div_req_t   div_req;
    div_rsp_t   div_rsp;
    commit_t    cmt;
    logic       slot_free;
    logic       commit_fire;

    ctl_state_t state_reg, state_next;

    // latched report, held from transfer to commit
    stk_size_t  size_reg;
    unused_t    unused_reg;
    err_t       err_reg;
    logic       last_reg;
    time_ms_t   time_reg;
    pct_t       pct_reg,   pct_next;

    logic                 accept;
    logic                 need_div;
    logic [WIDE_BITS-1:0] size_w;
    logic [WIDE_BITS-1:0] unused_w;
    logic [WIDE_BITS-1:0] used_w;

    suwm_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // used bytes clamp at zero when the unused figure exceeds the size
    assign size_w   = WIDE_BITS'(stack_bytes);
    assign unused_w = WIDE_BITS'(unused_bytes);
    assign used_w   = (size_w >= unused_w) ? size_w - unused_w : '0;

    assign accept   = item_valid && item_ready;
    // error reports and unknown sizes skip the divider, their percent is 0
    assign need_div = (report_error == '0) && (stack_bytes != '0);

    assign div_req.start = accept && need_div;
    assign div_req.size  = stack_bytes;
    assign div_req.used  = used_w[STACK_SIZE_BITS-1:0];

    suwm_pct_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // control sequencer: idle -> divide -> commit -> idle; reports that need no division go straight to commit
    always_comb
    begin
        state_next  = state_reg;
        pct_next    = pct_reg;
        item_ready  = 1'b0;
        commit_fire = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    pct_next   = '0;
                    state_next = need_div ? ST_CALC : ST_COMMIT;
                end
            end
            ST_CALC:
            begin
                if (div_rsp.done)
                begin
                    pct_next   = div_rsp.pct;
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                // a closing report needs the status register free
                if (!last_reg || slot_free)
                begin
                    commit_fire = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pct_reg <= pct_next;
        if (accept)
        begin
            size_reg   <= stack_bytes;
            unused_reg <= unused_bytes;
            err_reg    <= report_error;
            last_reg   <= last_of_scan;
            time_reg   <= scan_time_ms;
        end
    end

    assign cmt.fire   = commit_fire;
    assign cmt.size   = size_reg;
    assign cmt.unused = unused_reg;
    assign cmt.err    = err_reg;
    assign cmt.last   = last_reg;
    assign cmt.now    = time_reg;
    assign cmt.pct    = pct_reg;

    suwm_scan_acc u_acc (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmt                (cmt),
        .cfg                (cfg),
        .result_ready       (result_ready),
        .slot_free          (slot_free),
        .result_valid       (result_valid),
        .scans_completed    (scans_completed),
        .warn_total         (warn_total),
        .scan_warning       (scan_warning),
        .threads_seen       (threads_seen),
        .scan_error         (scan_error),
        .worst_now_size     (worst_now_size),
        .worst_now_unused   (worst_now_unused),
        .worst_now_percent  (worst_now_percent),
        .worst_ever_size    (worst_ever_size),
        .worst_ever_unused  (worst_ever_unused),
        .worst_ever_percent (worst_ever_percent),
        .scan_end_time_ms   (scan_end_time_ms)
    );

endmodule

`default_nettype wire

### sv/suwm_port_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module suwm_port_checker (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    input  wire logic                 item_ready,
    input  wire suwm_pkg::stk_size_t  stack_bytes,
    input  wire logic                 result_valid,
    input  wire logic                 result_ready,
    input  wire suwm_pkg::count_t     scans_completed,
    input  wire suwm_pkg::thr_count_t threads_seen,
    input  wire suwm_pkg::stk_size_t  worst_now_size,
    input  wire suwm_pkg::unused_t    worst_now_unused,
    input  wire suwm_pkg::pct_t       worst_now_percent,
    input  wire suwm_pkg::pct_t       worst_ever_percent
);
    import suwm_pkg::*;

    localparam pct_t PCT_MAX = PCT_BITS'(PCT_SCALE);

    // a stalled status transfer stays valid and holds its scan count
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(scans_completed))
        else $error("status changed while stalled");

    // a stalled report transfer stays valid and holds its stack size
    a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_ready |=> item_valid && $stable(stack_bytes))
        else $error("report changed while stalled");

    // a status always counts the closing report and percents stay in range
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> threads_seen != '0 && worst_now_percent <= PCT_MAX &&
                         worst_ever_percent <= PCT_MAX)
        else $error("status out of range");

    // an empty worst record carries no unused bytes and no percent
    a_empty_worst: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && worst_now_size == '0 |->
            worst_now_unused == '0 && worst_now_percent == '0)
        else $error("empty worst record not cleared");

endmodule

bind stack_usage_watermark_monitor_core suwm_port_checker u_port_checker (.*);

`default_nettype wire
